@@ design/address_delta_bitstream_decoder_core_defines.svh @@
// assertion macros shared by the decoder core modules
// each module that asserts must have clk and arst_n in scope
`ifndef ADDRESS_DELTA_BITSTREAM_DECODER_CORE_DEFINES_SVH
`define ADDRESS_DELTA_BITSTREAM_DECODER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ADBD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("adbd assertion failed");
`define ADBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adbd assertion failed");
`else
`define ADBD_ASSERT_IMPL(lbl, ante, cons)
`define ADBD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/adbd_pkg.sv @@
// shared types and constants for the address delta bitstream decoder
// no dependencies
package adbd_pkg;

	// width of a signed delta field
	localparam int DELTA_BITS = 16;

	// byte queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_COUNT   = 1'b1;

	// one input beat as held in the queue
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_beat_t;

	// queue head as seen by the decoder
	typedef struct packed {
		logic       valid;
		byte_beat_t beat;
	} queue_head_t;

endpackage

@@ design/address_delta_bitstream_decoder_core.sv @@
// top level of the prefix coded address delta decoder
// holds the configuration registers; uses adbd_pkg, adbd_byte_queue, adbd_bit_decoder
//
// channel   direction  handshake            payload
// input     in         in_valid / in_ready  stream_byte, byte_last
// result    out        out_valid/out_ready  address, record_last, underrun_error
// config    in         cfg_we               cfg_index, cfg_data
//
// a byte is walked in the bit decoder one code bit per cycle unless the decoder stalls, and may
// give one record in each; a byte that falls after the count is reached is dropped whole
// a byte marked last also closes the stream and gives any underrun beat
// a two entry byte queue accepts input while the decoder works; the result register
// stalls the decoder only in a cycle that produces a result beat
// reset clears all control state at once; there is no clearing pass

module address_delta_bitstream_decoder_core
	import adbd_pkg::*;
#(
	parameter int ADDR_BITS  = 48,
	parameter int COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            stream_byte,
	input  logic                  byte_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_BITS-1:0]  address,
	output logic                  record_last,
	output logic                  underrun_error,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COUNT_BITS-1:0] cfg_data
);

	logic                  format_version_q;
	logic [COUNT_BITS-1:0] record_count_q;
	byte_beat_t            in_beat;
	queue_head_t           head;
	logic                  pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_version_q <= 1'b0;
			record_count_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT_VERSION: format_version_q <= cfg_data[0];
				REG_RECORD_COUNT:   record_count_q   <= cfg_data;
				default:            record_count_q   <= record_count_q;
			endcase
		end
	end

	assign in_beat.data = stream_byte;
	assign in_beat.last = byte_last;

	// front: byte queue
	adbd_byte_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.head     (head),
		.pop      (pop)
	);

	// back: bit decoder and result register
	adbd_bit_decoder #(
		.ADDR_BITS  (ADDR_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_decoder (
		.clk            (clk),
		.arst_n         (arst_n),
		.format_version (format_version_q),
		.record_count   (record_count_q),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.address        (address),
		.record_last    (record_last),
		.underrun_error (underrun_error)
	);

endmodule

@@ design/adbd_byte_queue.sv @@
// front end: accepts stream bytes and holds them in a short queue
// depends on adbd_pkg and the core defines header
`include "address_delta_bitstream_decoder_core_defines.svh"

module adbd_byte_queue
	import adbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  byte_beat_t  in_beat,
	output queue_head_t head,
	input  logic        pop
);

	byte_beat_t               entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;
	logic                     push;

	// handshake and head view
	assign in_ready   = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != '0);
	assign head.beat  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_beat;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// checks
	`ADBD_ASSERT_IMPL(a_pop_not_empty, pop, count_q != '0)
	`ADBD_ASSERT_NEXT(a_fill_grows, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

@@ design/adbd_bit_decoder.sv @@
// back end: walks queued bytes one bit a cycle unless stalled, decodes prefix codes
// and drives the result register; depends on adbd_pkg and the defines header
`include "address_delta_bitstream_decoder_core_defines.svh"

module adbd_bit_decoder
	import adbd_pkg::*;
#(
	parameter int ADDR_BITS  = 48,
	parameter int COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  format_version,
	input  logic [COUNT_BITS-1:0] record_count,
	input  queue_head_t           head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_BITS-1:0]  address,
	output logic                  record_last,
	output logic                  underrun_error
);

	localparam int BL_W = $clog2(ADDR_BITS + 1);

	// decode phases
	localparam logic [2:0] PH_FIRST = 3'd0;
	localparam logic [2:0] PH_CODE0 = 3'd1;
	localparam logic [2:0] PH_CODE1 = 3'd2;
	localparam logic [2:0] PH_CODE2 = 3'd3;
	localparam logic [2:0] PH_DELTA = 3'd4;
	localparam logic [2:0] PH_ABS   = 3'd5;

	logic [2:0]            phase_q;
	logic [BL_W-1:0]       bits_left_q;
	logic [ADDR_BITS-1:0]  acc_q;
	logic [ADDR_BITS-1:0]  prev_q;
	logic [COUNT_BITS-1:0] records_done_q;
	logic                  draining_q;
	logic [2:0]            bit_idx_q;
	logic                  end_q;
	logic                  out_valid_q;
	logic [ADDR_BITS-1:0]  out_addr_q;
	logic                  out_last_q;
	logic                  out_err_q;

	logic                  bit_val;
	logic                  count_reached;
	logic                  stop;
	logic [ADDR_BITS-1:0]  acc_shift;
	logic [DELTA_BITS-1:0] delta;
	logic                  field_done;
	logic                  take_emit;
	logic                  use_sum;
	logic [ADDR_BITS-1:0]  operand;
	logic [ADDR_BITS-1:0]  sum;
	logic [ADDR_BITS-1:0]  emit_value;
	logic [COUNT_BITS-1:0] new_done;
	logic                  new_last;
	logic                  slot_ok;
	logic                  bit_go;
	logic                  drop_go;
	logic                  err;
	logic                  end_go;
	logic                  byte_done;
	logic                  out_load;

	// bit classification and next record value
	always_comb begin
		bit_val       = head.beat.data[bit_idx_q];
		count_reached = (records_done_q >= record_count);
		stop          = draining_q || count_reached;
		acc_shift     = {acc_q[ADDR_BITS-2:0], bit_val};
		delta         = acc_shift[DELTA_BITS-1:0];
		field_done    = (bits_left_q == BL_W'(1));
		take_emit     = 1'b0;
		use_sum       = 1'b1;
		operand       = ADDR_BITS'(1);
		unique case (phase_q)
			PH_FIRST, PH_ABS: begin
				take_emit = field_done;
				use_sum   = 1'b0;
			end
			PH_CODE0: begin
				take_emit = !bit_val;
			end
			PH_CODE1: begin
				take_emit = format_version && !bit_val;
				operand   = '1;
			end
			PH_DELTA: begin
				take_emit = field_done;
				operand   = {{(ADDR_BITS-DELTA_BITS){delta[DELTA_BITS-1]}}, delta};
			end
			default: begin
				take_emit = 1'b0;
			end
		endcase
		sum        = prev_q + operand;
		emit_value = use_sum ? sum : acc_shift;
		new_done   = records_done_q + 1'b1;
		new_last   = (new_done == record_count);
	end

	// step control
	always_comb begin
		slot_ok   = !out_valid_q || out_ready;
		bit_go    = head.valid && !end_q && !stop && (!take_emit || slot_ok);
		drop_go   = head.valid && !end_q && stop;
		err       = !count_reached && !draining_q;
		end_go    = head.valid && end_q && (!err || slot_ok);
		byte_done = (bit_go && (bit_idx_q == 3'd0)) || drop_go;
		pop       = (byte_done && !head.beat.last) || end_go;
		out_load  = (bit_go && take_emit) || (end_go && err);
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_FIRST;
			bits_left_q    <= BL_W'(ADDR_BITS);
			acc_q          <= '0;
			prev_q         <= '0;
			records_done_q <= '0;
			draining_q     <= 1'b0;
			bit_idx_q      <= 3'd7;
			end_q          <= 1'b0;
		end else if (bit_go) begin
			bit_idx_q <= bit_idx_q - 1'b1;
			if (bit_idx_q == 3'd0 && head.beat.last) begin
				end_q <= 1'b1;
			end
			unique case (phase_q)
				PH_FIRST, PH_ABS, PH_DELTA: begin
					acc_q       <= acc_shift;
					bits_left_q <= bits_left_q - 1'b1;
				end
				PH_CODE0: begin
					if (bit_val) begin
						phase_q <= PH_CODE1;
					end
				end
				PH_CODE1: begin
					if (!format_version) begin
						phase_q     <= bit_val ? PH_ABS : PH_DELTA;
						bits_left_q <= bit_val ? BL_W'(ADDR_BITS) : BL_W'(DELTA_BITS);
						acc_q       <= '0;
					end else if (bit_val) begin
						phase_q <= PH_CODE2;
					end
				end
				PH_CODE2: begin
					phase_q     <= bit_val ? PH_ABS : PH_DELTA;
					bits_left_q <= bit_val ? BL_W'(ADDR_BITS) : BL_W'(DELTA_BITS);
					acc_q       <= '0;
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
			// a finished record overrides the field update
			if (take_emit) begin
				prev_q         <= emit_value;
				records_done_q <= new_done;
				draining_q     <= new_last;
				phase_q        <= PH_CODE0;
				acc_q          <= '0;
			end
		end else if (drop_go) begin
			draining_q <= 1'b1;
			bit_idx_q  <= 3'd7;
			if (head.beat.last) begin
				end_q <= 1'b1;
			end
		end else if (end_go) begin
			phase_q        <= PH_FIRST;
			bits_left_q    <= BL_W'(ADDR_BITS);
			acc_q          <= '0;
			prev_q         <= '0;
			records_done_q <= '0;
			draining_q     <= 1'b0;
			bit_idx_q      <= 3'd7;
			end_q          <= 1'b0;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (end_q) begin
				out_addr_q <= '0;
				out_last_q <= 1'b0;
				out_err_q  <= 1'b1;
			end else begin
				out_addr_q <= emit_value;
				out_last_q <= new_last;
				out_err_q  <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign address        = out_addr_q;
	assign record_last    = out_last_q;
	assign underrun_error = out_err_q;

	// checks
	`ADBD_ASSERT_IMPL(a_err_beat_clean, out_valid_q && out_err_q, out_addr_q == '0 && !out_last_q)
	`ADBD_ASSERT_IMPL(a_no_overwrite, out_load, slot_ok)
	`ADBD_ASSERT_NEXT(a_stream_restart, end_go,
		phase_q == PH_FIRST && records_done_q == '0 && !draining_q)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for address_delta_bitstream_decoder_core: prefix-coded streams are
// built here, predicted by a behavioural decoder and checked beat by beat on the result side
// depends on adbd_pkg and the decoder core rtl

module tb_top
	import adbd_pkg::*;
();

	localparam int AW = 48;
	localparam int CW = 24;
	localparam logic [CW-1:0] COUNT_MAX = '1;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_BEATS = 160;

	// prefix codes as they appear on the wire
	localparam logic       CODE_INC      = 1'b0;
	localparam logic [1:0] CODE_DEC_V2   = 2'b10;
	localparam logic [1:0] CODE_DELTA_V1 = 2'b10;
	localparam logic [1:0] CODE_ABS_V1   = 2'b11;
	localparam logic [2:0] CODE_DELTA_V2 = 3'b110;
	localparam logic [2:0] CODE_ABS_V2   = 3'b111;

	typedef enum logic [2:0] {
		PH_FIRST, PH_CODE0, PH_CODE1, PH_CODE2, PH_DELTA, PH_ABS
	} dec_phase_e;

	typedef enum int {OP_INC, OP_DEC, OP_DELTA, OP_ABS} addr_op_e;

	typedef struct packed {
		logic [AW-1:0] addr;
		logic          rec_last;
		logic          underrun;
	} addr_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           stream_byte = '0;
	logic                 byte_last = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [AW-1:0]        address;
	logic                 record_last;
	logic                 underrun_error;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FORMAT_VERSION;
	logic [CW-1:0]        cfg_data = '0;

	// register copies as last written
	logic          fmt_v2;
	logic [CW-1:0] count_cfg;

	// decoder state tracked alongside the block
	dec_phase_e    dec_phase;
	int            bits_left;
	logic [AW-1:0] field_acc;
	logic [AW-1:0] prev_addr;
	logic [CW-1:0] recs_done;
	logic          draining;

	addr_rec_t     expected_recs[$];
	byte_beat_t    pending_beats[$];
	bit            code_bits[$];
	int            mismatches = 0;
	int            queued_beats = 0;
	bit            random_phase = 1'b0;

	address_delta_bitstream_decoder_core #(
		.ADDR_BITS(AW),
		.COUNT_BITS(CW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stream_byte(stream_byte),
		.byte_last(byte_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.address(address),
		.record_last(record_last),
		.underrun_error(underrun_error),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void note_failure(string msg);
		mismatches++;
		if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
	endfunction

	// ---------------------------------------------------------------- predictor

	function automatic void stream_reset();
		dec_phase = PH_FIRST;
		bits_left = AW;
		field_acc = '0;
		prev_addr = '0;
		recs_done = '0;
		draining = 1'b0;
	endfunction

	function automatic void emit_addr(logic [AW-1:0] value);
		addr_rec_t r;
		prev_addr = value;
		recs_done = recs_done + 1'b1;
		r.addr = value;
		r.rec_last = (recs_done == count_cfg);
		r.underrun = 1'b0;
		expected_recs.push_back(r);
		if (r.rec_last) draining = 1'b1;
		dec_phase = PH_CODE0;
		field_acc = '0;
	endfunction

	// bit after the last prefix bit: 0 picks a delta, 1 an absolute address
	function automatic void open_field(logic b);
		dec_phase = b ? PH_ABS : PH_DELTA;
		bits_left = b ? AW : DELTA_BITS;
		field_acc = '0;
	endfunction

	function automatic void decode_bit(logic b);
		logic [AW-1:0] delta_ext;
		case (dec_phase)
			PH_FIRST, PH_ABS: begin
				field_acc = {field_acc[AW-2:0], b};
				if (bits_left > 0) bits_left--;
				if (bits_left == 0) emit_addr(field_acc);
			end
			PH_CODE1: begin
				if (!fmt_v2) begin
					open_field(b);
				end else if (!b) begin
					emit_addr(prev_addr - 1'b1);
				end else begin
					dec_phase = PH_CODE2;
				end
			end
			PH_CODE2: begin
				open_field(b);
			end
			PH_DELTA: begin
				field_acc = AW'({field_acc[DELTA_BITS-2:0], b});
				if (bits_left > 0) bits_left--;
				if (bits_left == 0) begin
					delta_ext = {{(AW-DELTA_BITS){field_acc[DELTA_BITS-1]}},
						field_acc[DELTA_BITS-1:0]};
					emit_addr(prev_addr + delta_ext);
				end
			end
			default: begin
				if (!b) emit_addr(prev_addr + 1'b1);
				else dec_phase = PH_CODE1;
			end
		endcase
	endfunction

	// one accepted byte: msb first, stop once the count is met, close on the last byte
	function automatic void decode_beat(logic [7:0] data, logic last);
		addr_rec_t r;
		bit stop;
		stop = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!stop) begin
				if (recs_done >= count_cfg) draining = 1'b1;
				if (draining) stop = 1'b1;
				else decode_bit(data[i]);
			end
		end
		if (last) begin
			if (recs_done < count_cfg && !draining) begin
				r = '{addr: '0, rec_last: 1'b0, underrun: 1'b1};
				expected_recs.push_back(r);
			end
			stream_reset();
		end
	endfunction

	// ---------------------------------------------------------------- stream building

	function automatic void push_beat(logic [7:0] data, logic last);
		byte_beat_t bt;
		bt.data = data;
		bt.last = last;
		pending_beats.push_back(bt);
		queued_beats++;
	endfunction

	function automatic void put_bits(logic [63:0] value, int n);
		for (int i = n - 1; i >= 0; i--) code_bits.push_back(value[i]);
	endfunction

	// pad to whole bytes with random filler and queue them, last flag on the final one
	function automatic void pack_bits(bit mark_last);
		logic [7:0] data;
		int nbytes;
		data = '0;
		while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(0, 1)));
		nbytes = code_bits.size() / 8;
		if (nbytes == 0 && mark_last) push_beat(8'($urandom), 1'b1);
		for (int k = 0; k < nbytes; k++) begin
			for (int j = 0; j < 8; j++) data = {data[6:0], code_bits.pop_front()};
			push_beat(data, mark_last && k == nbytes - 1);
		end
	endfunction

	function automatic void put_op(addr_op_e op, logic [AW-1:0] value);
		case (op)
			OP_INC: put_bits(64'(CODE_INC), 1);
			OP_DEC: put_bits(64'(CODE_DEC_V2), 2);
			OP_DELTA: begin
				if (fmt_v2) put_bits(64'(CODE_DELTA_V2), 3);
				else put_bits(64'(CODE_DELTA_V1), 2);
				put_bits(64'(value), DELTA_BITS);
			end
			default: begin
				if (fmt_v2) put_bits(64'(CODE_ABS_V2), 3);
				else put_bits(64'(CODE_ABS_V1), 2);
				put_bits(64'(value), AW);
			end
		endcase
	endfunction

	function automatic logic [AW-1:0] rand_addr();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return r[AW-1:0];
		endcase
	endfunction

	// absolute start, then random codes under the current format, optional trailing bytes
	function automatic void queue_stream(int codes, int filler, bit close);
		int sel;
		logic [AW-1:0] value;
		put_bits(64'(rand_addr()), AW);
		for (int k = 0; k < codes; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				put_op(OP_INC, '0);
			end else if (fmt_v2 && sel < 60) begin
				put_op(OP_DEC, '0);
			end else if (sel < 80) begin
				// extreme deltas now and then
				case ($urandom_range(0, 3))
					0: value = AW'(16'h8000);
					1: value = AW'(16'h7FFF);
					default: value = AW'($urandom);
				endcase
				put_op(OP_DELTA, value);
			end else begin
				put_op(OP_ABS, rand_addr());
			end
		end
		for (int k = 0; k < filler; k++) put_bits(64'($urandom), 8);
		pack_bits(close);
	endfunction

	// ---------------------------------------------------------------- configuration

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FORMAT_VERSION) fmt_v2 = value[0];
		else count_cfg = value;
	endtask

	task automatic set_config(bit v2, logic [CW-1:0] count);
		logic [CW-1:0] fmt_word;
		// upper bits of the format word are junk and must be ignored
		fmt_word = CW'($urandom);
		fmt_word[0] = v2;
		write_reg(REG_FORMAT_VERSION, fmt_word);
		write_reg(REG_RECORD_COUNT, count);
	endtask

	// all bytes taken and all results back, then let a byte that gives nothing finish
	task automatic wait_idle();
		int waited;
		waited = 0;
		while ((pending_beats.size() != 0 || in_valid || expected_recs.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (waited >= DRAIN_LIMIT) begin
			note_failure($sformatf("stalled with %0d results outstanding",
				expected_recs.size()));
			expected_recs.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- input driver

	int burst_left = 0;
	int gap_left = 0;

	// byte side: bursts of beats with random gaps between them
	always @(posedge clk or negedge arst_n) begin : beat_driver
		byte_beat_t bt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) decode_beat(stream_byte, byte_last);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					bt = pending_beats.pop_front();
					in_valid <= 1'b1;
					stream_byte <= bt.data;
					byte_last <= bt.last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- result monitor

	logic [15:0] ready_pattern = 16'hFFFF;
	int          pattern_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	// result side: compare with the oldest prediction, stall on a rolling pattern
	always @(posedge clk or negedge arst_n) begin : result_monitor
		addr_rec_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_recs.size() == 0) begin
					note_failure($sformatf("unexpected beat addr %h last %b underrun %b",
						address, record_last, underrun_error));
				end else begin
					want = expected_recs.pop_front();
					if (address !== want.addr || record_last !== want.rec_last ||
							underrun_error !== want.underrun)
						note_failure($sformatf(
							"expected addr %h last %b underrun %b, got %h %b %b",
							want.addr, want.rec_last, want.underrun,
							address, record_last, underrun_error));
				end
			end
			// fresh stall pattern every so often, a third of them with no stalls
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(50, 300);
				ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
					(16'($urandom) | 16'h0001);
			end else begin
				pattern_left--;
				ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			end
			// one long hold-off early in the random part so the block backs up
			if (random_phase && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ready_pattern[0];
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		int rand_target;
		int phase_no;
		int streams;
		int c;
		int sel;
		bit open_end;
		bit close;
		logic [CW-1:0] cnt;

		fmt_v2 = 1'b0;
		count_cfg = '0;
		stream_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: v1 codes and a zero count, so the buffer is dropped whole
		push_beat(8'hFF, 1'b1);
		wait_idle();

		// v2: every code, wrap at both ends, most negative delta, leftover bits after the count
		set_config(1'b1, 24'd5);
		put_bits(64'({AW{1'b1}}), AW);
		put_op(OP_INC, '0);
		put_op(OP_DEC, '0);
		put_op(OP_DELTA, AW'(16'h8000));
		put_op(OP_ABS, '0);
		pack_bits(1'b1);
		wait_idle();

		// v1: one byte of eight increments closing the count, then an underrun
		set_config(1'b0, 24'd9);
		put_bits('0, AW);
		put_bits(64'h00, 8);
		pack_bits(1'b1);
		push_beat(8'h00, 1'b1);

		// random phases, each under its own settings
		rand_target = queued_beats + RANDOM_BEATS;
		phase_no = 0;
		while (queued_beats < rand_target) begin
			wait_idle();
			sel = $urandom_range(0, 9);
			case (phase_no)
				0: cnt = 24'd8;
				1: cnt = 24'd1;
				2: cnt = COUNT_MAX;
				default: begin
					if (sel == 0) cnt = '0;
					else if (sel == 1) cnt = COUNT_MAX;
					else if (sel == 2) cnt = CW'($urandom_range(13, 2**CW - 1));
					else cnt = CW'($urandom_range(1, 9));
				end
			endcase
			set_config(1'($urandom_range(0, 1)), cnt);
			streams = $urandom_range(2, 5);
			// an open stream carries over into the next settings
			open_end = (phase_no == 0) || ($urandom_range(0, 3) == 0);
			c = int'(count_cfg);
			for (int s = 0; s < streams; s++) begin
				close = !(open_end && s == streams - 1);
				if (phase_no > 0 && $urandom_range(0, 7) == 0) begin
					// noise bytes
					repeat ($urandom_range(1, 4))
						push_beat(8'($urandom), $urandom_range(0, 2) == 0);
				end else if (c == 0) begin
					queue_stream($urandom_range(0, 3), 0, close);
				end else if (c > 12) begin
					queue_stream($urandom_range(2, 10), 0, close);
				end else if (c >= 2 && (!close || $urandom_range(0, 5) == 0)) begin
					// short of the count: underrun, or a live stream left open
					queue_stream($urandom_range(0, c - 2), 0, close);
				end else begin
					queue_stream(c - 1, $urandom_range(0, 2), close);
				end
			end
			if (phase_no == 0) random_phase = 1'b1;
			phase_no++;
		end

		wait_idle();
		if (mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	// hard stop
	initial begin : watchdog
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/adbd_pkg.sv
design/adbd_byte_queue.sv
design/adbd_bit_decoder.sv
design/address_delta_bitstream_decoder_core.sv
tb/tb_top.sv
